FILE: hdl/lkd_pkg.sv
// ----------------------------------------------------------------------------
// lkd_pkg
// Shared constants and types for the keyed byte descrambler.
// ----------------------------------------------------------------------------
`default_nettype none

package lkd_pkg;

   localparam int unsigned KEY_W      = 32;
   localparam int unsigned ENTRY_W    = 15;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned POS_W      = 8;
   localparam int unsigned POS_RANGE  = 256;
   localparam int unsigned CSR_ADDR_W = 2;

   localparam logic [KEY_W-1:0] GEN_MUL = 32'h0003_43FD;
   localparam logic [KEY_W-1:0] GEN_ADD = 32'h0026_9EC3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_KEY    = 2'd0,
      CSR_ENABLE = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic busy;
      logic wr_en;
   } fill_status_type;

endpackage

`default_nettype wire

FILE: hdl/lkd_keygen.sv
// ----------------------------------------------------------------------------
// lkd_keygen
// Generator sweep: steps the LCG once per cycle while a fill is busy and writes bits
// 30..16 of each next value into successive keystream table entries.
// ----------------------------------------------------------------------------
`default_nettype none

module lkd_keygen
   import lkd_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 256,
   parameter int unsigned IDX_W       = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                key_load,
   input  wire logic [KEY_W-1:0]    key_value,
   output fill_status_type          status,
   output logic [IDX_W-1:0]         wr_addr,
   output logic [ENTRY_W-1:0]       wr_entry
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   logic [KEY_W-1:0] x_ff, x_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [KEY_W-1:0] x_next;

   assign x_next = KEY_W'(x_ff * GEN_MUL) + GEN_ADD;

   always_comb begin
      x_in    = x_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (key_load) begin
         x_in    = key_value;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in   = x_next;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_IDX) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff    <= '0;
         cnt_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         x_ff    <= x_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign status.busy  = busy_ff;
   assign status.wr_en = busy_ff && !key_load;
   assign wr_addr      = cnt_ff;
   assign wr_entry     = x_next[30:16];

endmodule

`default_nettype wire

FILE: hdl/lcg_keyed_byte_descrambler.sv
// ----------------------------------------------------------------------------
// lcg_keyed_byte_descrambler
// Descrambles a byte stream with a keystream table filled by an LCG seeded
// from a 32-bit key: out = (byte ^ entry[7:0]) - entry[14:8] when enabled.
// ----------------------------------------------------------------------------
//  channel | dir | tdata / data               | sideband
//  req_    | in  | [7:0] data_byte,[15:8] pos | tlast = chunk_end
//  rsp_    | out | [7:0] plain_byte           | tlast = last_of_chunk
//  csr_    | in  | wdata[31:0], index 0 key,  | ready always high
//          |     | index 1 enable             |
//
//  Three register stages (index, table read, result); one byte per cycle while
//  neither the output nor a table fill stalls. Each stage loads when empty or
//  when the next drains. After reset and after every key write the table is
//  refilled, one entry per cycle; req_tready stays low meanwhile.
//  Reset is synchronous, clears valid bits and the enable, restarts the fill.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_keyed_byte_descrambler
   import lkd_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,   // [7:0] data_byte, [15:8] position
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [7:0] plain_byte
   output logic                       rsp_tlast,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [KEY_W-1:0]      csr_wdata
);

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

   logic                csr_fire;
   logic                key_load;
   logic                enable_ff, enable_in;
   fill_status_type     fill_st;
   logic [IDX_W-1:0]    fill_addr;
   logic [ENTRY_W-1:0]  fill_entry;

   logic [ENTRY_W-1:0]  table_mem [TABLE_DEPTH];
   logic [IDX_W-1:0]    pos_map [POS_RANGE];

   logic                rdy1, rdy2, rdy3;
   logic                req_fire;

   logic                v1_ff, v2_ff, v3_ff;
   logic [IDX_W-1:0]    idx1_ff;
   logic [BYTE_W-1:0]   byte1_ff, byte2_ff, byte3_ff, byte3_in;
   logic                last1_ff, last2_ff, last3_ff;
   logic [ENTRY_W-1:0]  entry2_ff;
   logic [BYTE_W-1:0]   mixed;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign key_load  = csr_fire && (csr_index == CSR_KEY);

   always_comb begin
      enable_in = enable_ff;
      if (csr_fire) begin
         case (csr_index)
            CSR_ENABLE: enable_in = csr_wdata[0];
            default:    enable_in = enable_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
      end
   end

   lkd_keygen #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_keygen (
      .clock     (clock),
      .reset     (reset),
      .key_load  (key_load),
      .key_value (csr_wdata),
      .status    (fill_st),
      .wr_addr   (fill_addr),
      .wr_entry  (fill_entry)
   );

   for (genvar g = 0; g < POS_RANGE; g++) begin : g_pos_map
      assign pos_map[g] = IDX_W'(g % TABLE_DEPTH);
   end

   assign rdy3       = !v3_ff || rsp_tready;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1 && !fill_st.busy;
   assign req_fire   = req_tvalid && req_tready;

   // stage 1: table index
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         idx1_ff  <= pos_map[req_tdata[15:8]];
         byte1_ff <= req_tdata[7:0];
         last1_ff <= req_tlast;
      end
   end

   // table write by the fill engine, registered read for stage 2
   always_ff @(posedge clock) begin
      if (fill_st.wr_en) begin
         table_mem[fill_addr] <= fill_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         entry2_ff <= table_mem[idx1_ff];
         byte2_ff  <= byte1_ff;
         last2_ff  <= last1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
   end

   // stage 3: descramble (or pass through when disabled) into the output register
   assign mixed    = (byte2_ff ^ entry2_ff[7:0]) - {1'b0, entry2_ff[14:8]};
   assign byte3_in = enable_ff ? mixed : byte2_ff;

   always_ff @(posedge clock) begin
      if (rdy3) begin
         byte3_ff <= byte3_in;
         last3_ff <= last2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = byte3_ff;
   assign rsp_tlast  = last3_ff;

`ifndef SYNTHESIS
   a_no_accept_while_fill: assert property (@(posedge clock) disable iff (reset)
      fill_st.busy |-> !req_tready)
      else $error("input transfer taken while table fill in progress");

   a_key_starts_fill: assert property (@(posedge clock) disable iff (reset)
      key_load |=> fill_st.busy)
      else $error("key write did not start a table fill");

   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> v1_ff)
      else $error("accepted transfer did not enter stage 1");
`endif

endmodule

`default_nettype wire
